>>> rtl/wfdi_pkg.sv
// ----------------------------------------------------------------------------
// wfdi_pkg
// shared types, constants and coefficient tables of the washout filter
// ----------------------------------------------------------------------------
package wfdi_pkg;

    // default internal word width, signed Q(n-16).16
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths
    localparam int ACCEL_W    = 24;
    localparam int RES_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int HALF_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ALPHA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POS_ALPHA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(2);

    // register reset values
    localparam logic [GAIN_W-1:0] ACCEL_ALPHA_RST = GAIN_W'(31949);
    localparam logic [GAIN_W-1:0] POS_ALPHA_RST   = GAIN_W'(32440);
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(83886);

    // operand pair of the shared multiplier
    typedef enum logic [3:0] {
        MS_NONE,
        MS_U0,
        MS_U1,
        MS_U2,
        MS_U3,
        MS_Y1,
        MS_Y2,
        MS_Y3,
        MS_AGAIN,
        MS_PGAIN,
        MS_HH,
        MS_HL
    } t_mul_sel;

    // accumulator and result register operation
    typedef enum logic [3:0] {
        AO_NONE,
        AO_CLR,
        AO_WSUM,
        AO_WFIN,
        AO_AFIN,
        AO_HSAVE,
        AO_HSUM,
        AO_VFIN,
        AO_PFIN,
        AO_QFIN
    } t_acc_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_W0,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_W4,
        ST_W5,
        ST_W6,
        ST_WLAST,
        ST_WFIN,
        ST_AMUL,
        ST_AFIN,
        ST_VHH,
        ST_VHL,
        ST_VSUM,
        ST_VFIN,
        ST_PHH,
        ST_PHL,
        ST_PSUM,
        ST_PFIN,
        ST_QMUL,
        ST_QFIN
    } t_state;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     capture;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    // washout coefficient magnitudes, unsigned q0.16
    function automatic logic [GAIN_W-1:0] coef_mag(input t_mul_sel sel);
        unique case (sel)
            MS_U0:   return GAIN_W'(59231);
            MS_U1:   return GAIN_W'(14523);
            MS_U2:   return GAIN_W'(59304);
            MS_U3:   return GAIN_W'(14451);
            MS_Y1:   return GAIN_W'(2017);
            MS_Y2:   return GAIN_W'(55516);
            MS_Y3:   return GAIN_W'(12039);
            default: return '0;
        endcase
    endfunction

    // sign applied to the rounded term in the sum
    function automatic logic coef_neg(input t_mul_sel sel);
        unique case (sel)
            MS_U1, MS_U2, MS_Y3: return 1'b1;
            default:             return 1'b0;
        endcase
    endfunction

endpackage

>>> rtl/wfdi_if.sv
// ----------------------------------------------------------------------------
// wfdi channel interfaces
// sample, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface wfdi_in_if;
    import wfdi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel_sample;

    modport source (output valid, output accel_sample, input ready);
    modport sink   (input valid, input accel_sample, output ready);
endinterface

interface wfdi_out_if;
    import wfdi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] washout_accel;
    logic signed [RES_W-1:0] hp_accel;
    logic signed [RES_W-1:0] velocity;
    logic signed [RES_W-1:0] hp_position;

    modport source (output valid, output washout_accel, output hp_accel,
                    output velocity, output hp_position, input ready);
    modport sink   (input valid, input washout_accel, input hp_accel,
                    input velocity, input hp_position, output ready);
endinterface

interface wfdi_cfg_if;
    import wfdi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/washout_filter_double_integrator.sv
// ----------------------------------------------------------------------------
// washout_filter_double_integrator
// third-order washout filter, acceleration high-pass, two trapezoidal
// integrations and a position high-pass, one result per sample
// ----------------------------------------------------------------------------
//  channel    | dir | payload                                      | request
//  -----------+-----+----------------------------------------------+------------------
//  i_accel    | in  | accel_sample (s24, q8.16)                    | valid & ready
//  o_result   | out | washout_accel, hp_accel, velocity,           | valid & ready
//             |     | hp_position (s32, q16.16 each)               |
//  i_cfg      | in  | index (8), data (24)                         | valid & ready
//
//  a sample runs through the step sequence to the result register, and the
//  next request is taken on the cycle after that; the pace is set by the one
//  shared multiplier and the chain of dependent filter stages behind it
//  reset is synchronous and active low; it restores the register defaults and
//  clears the filter history at once, no clearing pass
//  a result waits in the output register while the next sample is computed;
//  only the final step holds if that register has not yet been emptied
//  register writes are always taken (ready stays high)
// ----------------------------------------------------------------------------
module washout_filter_double_integrator #(
    parameter int DATA_WIDTH = wfdi_pkg::DEF_DATA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wfdi_in_if.sink    i_accel,
    wfdi_cfg_if.sink   i_cfg,
    wfdi_out_if.source o_result
);
    import wfdi_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: one state per multiplier issue or combine step
    wfdi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accel  (i_accel),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: multiplier, accumulator, filter history, output register
    wfdi_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_accel_sample (i_accel.accel_sample),
        .i_cfg          (i_cfg),
        .o_result       (o_result)
    );

endmodule

>>> rtl/wfdi_ctrl.sv
// ----------------------------------------------------------------------------
// wfdi_ctrl
// step sequencer: issues multiplier and accumulator commands per sample
// ----------------------------------------------------------------------------
module wfdi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wfdi_in_if.sink           i_accel,
    input  wfdi_pkg::t_status i_status,
    output wfdi_pkg::t_cmd    o_cmd
);
    import wfdi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_accel.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.mul_sel = MS_NONE;
        o_cmd.acc_op  = AO_NONE;
        o_cmd.capture = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.acc_op  = AO_CLR;
                o_cmd.capture = i_accel.valid;
                if (i_accel.valid) begin
                    n_state = ST_W0;
                end
            end
            ST_W0: begin
                o_cmd.mul_sel = MS_U0;
                n_state       = ST_W1;
            end
            ST_W1: begin
                o_cmd.mul_sel = MS_U1;
                o_cmd.acc_op  = AO_WSUM;
                n_state       = ST_W2;
            end
            ST_W2: begin
                o_cmd.mul_sel = MS_U2;
                o_cmd.acc_op  = AO_WSUM;
                n_state       = ST_W3;
            end
            ST_W3: begin
                o_cmd.mul_sel = MS_U3;
                o_cmd.acc_op  = AO_WSUM;
                n_state       = ST_W4;
            end
            ST_W4: begin
                o_cmd.mul_sel = MS_Y1;
                o_cmd.acc_op  = AO_WSUM;
                n_state       = ST_W5;
            end
            ST_W5: begin
                o_cmd.mul_sel = MS_Y2;
                o_cmd.acc_op  = AO_WSUM;
                n_state       = ST_W6;
            end
            ST_W6: begin
                o_cmd.mul_sel = MS_Y3;
                o_cmd.acc_op  = AO_WSUM;
                n_state       = ST_WLAST;
            end
            ST_WLAST: begin
                o_cmd.acc_op = AO_WSUM;
                n_state      = ST_WFIN;
            end
            ST_WFIN: begin
                o_cmd.acc_op = AO_WFIN;
                n_state      = ST_AMUL;
            end
            ST_AMUL: begin
                o_cmd.mul_sel = MS_AGAIN;
                n_state       = ST_AFIN;
            end
            ST_AFIN: begin
                o_cmd.acc_op = AO_AFIN;
                n_state      = ST_VHH;
            end
            ST_VHH: begin
                o_cmd.mul_sel = MS_HH;
                n_state       = ST_VHL;
            end
            ST_VHL: begin
                o_cmd.mul_sel = MS_HL;
                o_cmd.acc_op  = AO_HSAVE;
                n_state       = ST_VSUM;
            end
            ST_VSUM: begin
                o_cmd.acc_op = AO_HSUM;
                n_state      = ST_VFIN;
            end
            ST_VFIN: begin
                o_cmd.acc_op = AO_VFIN;
                n_state      = ST_PHH;
            end
            ST_PHH: begin
                o_cmd.mul_sel = MS_HH;
                n_state       = ST_PHL;
            end
            ST_PHL: begin
                o_cmd.mul_sel = MS_HL;
                o_cmd.acc_op  = AO_HSAVE;
                n_state       = ST_PSUM;
            end
            ST_PSUM: begin
                o_cmd.acc_op = AO_HSUM;
                n_state      = ST_PFIN;
            end
            ST_PFIN: begin
                o_cmd.acc_op = AO_PFIN;
                n_state      = ST_QMUL;
            end
            ST_QMUL: begin
                o_cmd.mul_sel = MS_PGAIN;
                n_state       = ST_QFIN;
            end
            ST_QFIN: begin
                // hold until the output register can take the result
                if (!i_status.out_busy) begin
                    o_cmd.acc_op = AO_QFIN;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/wfdi_dpath.sv
// ----------------------------------------------------------------------------
// wfdi_dpath
// shared multiplier, accumulator, filter state, registers and output stage
// ----------------------------------------------------------------------------
module wfdi_dpath #(
    parameter int DATA_WIDTH = wfdi_pkg::DEF_DATA_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wfdi_pkg::t_cmd                         i_cmd,
    output wfdi_pkg::t_status                      o_status,
    input  logic signed [wfdi_pkg::ACCEL_W-1:0]    i_accel_sample,
    wfdi_cfg_if.sink                               i_cfg,
    wfdi_out_if.source                             o_result
);
    import wfdi_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int XW = W + 1;
    localparam int MW = W + 2;
    localparam int PW = W + 19;

    localparam logic signed [PW-1:0] SAT_HI   = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO   = ~SAT_HI;
    localparam logic signed [PW-1:0] SAT32_HI = {{(PW-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT32_LO = ~SAT32_HI;
    localparam logic signed [PW-1:0] HALF15   = PW'(16384);
    localparam logic signed [PW-1:0] HALF16   = PW'(32768);
    localparam logic signed [PW-1:0] HALF23   = PW'(8388608);

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [RES_W-1:0] sat32(input logic signed [PW-1:0] v);
        if (v > SAT32_HI) begin
            return SAT32_HI[RES_W-1:0];
        end else if (v < SAT32_LO) begin
            return SAT32_LO[RES_W-1:0];
        end
        return v[RES_W-1:0];
    endfunction

    // registers
    logic        [GAIN_W-1:0]  r_accel_alpha;
    logic        [GAIN_W-1:0]  r_pos_alpha;
    logic        [HALF_W-1:0]  r_half_period;

    // filter state
    logic signed [ACCEL_W-1:0] r_ih [3];
    logic signed [W-1:0]       r_wh [3];
    logic signed [W-1:0]       r_prev_a;
    logic signed [W-1:0]       r_prev_v;
    logic signed [W-1:0]       r_prev_p;
    logic signed [W-1:0]       r_prev_q;

    // working registers
    logic signed [ACCEL_W-1:0] r_u;
    logic signed [PW-1:0]      r_prod;
    logic                      r_neg;
    logic signed [PW-1:0]      r_hh;
    logic signed [PW-1:0]      r_acc;
    logic signed [W-1:0]       r_y;
    logic signed [W-1:0]       r_a;
    logic signed [W-1:0]       r_v;
    logic signed [W-1:0]       r_p;
    logic signed [W-1:0]       r_inner;
    logic signed [XW-1:0]      r_x;

    // output stage
    logic                      r_out_valid;
    logic signed [RES_W-1:0]   r_o_wash;
    logic signed [RES_W-1:0]   r_o_hpa;
    logic signed [RES_W-1:0]   r_o_vel;
    logic signed [RES_W-1:0]   r_o_hpp;

    logic signed [MW-1:0]      m_a;
    logic        [GAIN_W-1:0]  m_b;
    logic signed [PW-1:0]      n_term;
    logic signed [PW-1:0]      n_gain;
    logic signed [PW-1:0]      n_half;
    logic signed [W-1:0]       n_y;
    logic signed [W-1:0]       n_v;
    logic signed [W-1:0]       n_p;
    logic                      commit;

    assign i_cfg.ready       = 1'b1;
    assign o_status.out_busy = r_out_valid && !o_result.ready;
    assign commit            = (i_cmd.acc_op == AO_QFIN);

    // operand selection
    always_comb begin
        m_a = '0;
        m_b = coef_mag(i_cmd.mul_sel);
        unique case (i_cmd.mul_sel)
            MS_U0:    m_a = MW'(r_u);
            MS_U1:    m_a = MW'(r_ih[0]);
            MS_U2:    m_a = MW'(r_ih[1]);
            MS_U3:    m_a = MW'(r_ih[2]);
            MS_Y1:    m_a = MW'(r_wh[0]);
            MS_Y2:    m_a = MW'(r_wh[1]);
            MS_Y3:    m_a = MW'(r_wh[2]);
            MS_AGAIN: begin
                m_a = MW'(r_inner);
                m_b = r_accel_alpha;
            end
            MS_PGAIN: begin
                m_a = MW'(r_inner);
                m_b = r_pos_alpha;
            end
            MS_HH: begin
                m_a = MW'(r_x);
                m_b = GAIN_W'(r_half_period[HALF_W-1:12]);
            end
            MS_HL: begin
                m_a = MW'(r_x);
                m_b = GAIN_W'(r_half_period[11:0]);
            end
            default:  m_a = '0;
        endcase
    end

    // rounding, half-period scaling and saturation
    always_comb begin
        n_term = (r_prod + HALF16) >>> 16;
        n_gain = PW'(sat_w((r_prod + HALF15) >>> 15));
        n_half = r_acc >>> 12;
        n_y    = sat_w(r_acc);
        n_v    = sat_w(PW'(r_prev_v) + n_half);
        n_p    = sat_w(PW'(r_prev_p) + n_half);
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_alpha <= ACCEL_ALPHA_RST;
            r_pos_alpha   <= POS_ALPHA_RST;
            r_half_period <= HALF_PERIOD_RST;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ih[i] <= '0;
                r_wh[i] <= '0;
            end
            r_prev_a <= '0;
            r_prev_v <= '0;
            r_prev_p <= '0;
            r_prev_q <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_ACCEL_ALPHA: r_accel_alpha <= i_cfg.data[GAIN_W-1:0];
                    REG_POS_ALPHA:   r_pos_alpha   <= i_cfg.data[GAIN_W-1:0];
                    REG_HALF_PERIOD: r_half_period <= i_cfg.data[HALF_W-1:0];
                    default: ;
                endcase
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit) begin
                r_ih[2]  <= r_ih[1];
                r_ih[1]  <= r_ih[0];
                r_ih[0]  <= r_u;
                r_wh[2]  <= r_wh[1];
                r_wh[1]  <= r_wh[0];
                r_wh[0]  <= r_y;
                r_prev_a <= r_a;
                r_prev_v <= r_v;
                r_prev_p <= r_p;
                r_prev_q <= n_gain[W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_u <= i_accel_sample;
        end
        if (i_cmd.mul_sel != MS_NONE) begin
            r_prod <= m_a * $signed({1'b0, m_b});
            r_neg  <= coef_neg(i_cmd.mul_sel);
        end
        unique case (i_cmd.acc_op)
            AO_NONE: ;
            AO_CLR:  r_acc <= '0;
            AO_WSUM: r_acc <= r_neg ? r_acc - n_term : r_acc + n_term;
            AO_WFIN: begin
                r_y     <= n_y;
                r_inner <= sat_w(PW'(r_prev_a) + PW'(n_y) - PW'(r_wh[0]));
            end
            AO_AFIN: begin
                r_a <= n_gain[W-1:0];
                r_x <= XW'(n_gain) + XW'(r_prev_a);
            end
            AO_HSAVE: r_hh <= r_prod;
            AO_HSUM:  r_acc <= r_hh + ((r_prod + HALF23) >>> 12);
            AO_VFIN: begin
                r_v <= n_v;
                r_x <= XW'(n_v) + XW'(r_prev_v);
            end
            AO_PFIN: begin
                r_p     <= n_p;
                r_inner <= sat_w(PW'(r_prev_q) + PW'(n_p) - PW'(r_prev_p));
            end
            AO_QFIN: begin
                r_o_wash <= sat32(PW'(r_y));
                r_o_hpa  <= sat32(PW'(r_a));
                r_o_vel  <= sat32(PW'(r_v));
                r_o_hpp  <= sat32(n_gain);
            end
            default: ;
        endcase
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.washout_accel = r_o_wash;
    assign o_result.hp_accel      = r_o_hpa;
    assign o_result.velocity      = r_o_vel;
    assign o_result.hp_position   = r_o_hpp;

endmodule

>>> rtl/wfdi_checker.sv
// ----------------------------------------------------------------------------
// wfdi_checker
// port-level checks on sample and result ordering
// ----------------------------------------------------------------------------
module wfdi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_wash,
    input logic [31:0] i_out_hpa,
    input logic [31:0] i_out_vel,
    input logic [31:0] i_out_hpp
);
    logic       in_req;
    logic       out_req;
    logic [1:0] r_pend;

    assign in_req  = i_in_valid && i_in_ready;
    assign out_req = i_out_valid && i_out_ready;

    // samples taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_req && !out_req) begin
            r_pend <= r_pend + 2'd1;
        end else if (out_req && !in_req) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |=> !i_in_ready)
        else $error("sample taken while another is in flight");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("wrong port state after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req |-> r_pend != 2'd0)
        else $error("result delivered with no sample pending");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |-> r_pend <= 2'd1)
        else $error("too many samples outstanding");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_wash)
            && $stable(i_out_hpa) && $stable(i_out_vel) && $stable(i_out_hpp))
        else $error("stalled result changed");

endmodule

bind washout_filter_double_integrator wfdi_checker u_wfdi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_accel.valid),
    .i_in_ready  (i_accel.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_wash  (o_result.washout_accel),
    .i_out_hpa   (o_result.hp_accel),
    .i_out_vel   (o_result.velocity),
    .i_out_hpp   (o_result.hp_position)
);
